// File: hdl/dwc3_pkg.sv
// Package for the depthwise 3x3 convolution block: sizes, register indexes,
// item and command structs. Used by every module of the block but dwc3_ram.
`timescale 1ns / 1ps
`default_nettype none
package dwc3_pkg;

  localparam int CHANNELS     = 64;
  localparam int MAX_OUT_ROWS = 64;
  localparam int MAX_OUT_COLS = 64;

  localparam int KSIZE      = 3;
  localparam int TAPS       = KSIZE * KSIZE;
  localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_DIM    = (MAX_OUT_ROWS > MAX_OUT_COLS) ? MAX_OUT_ROWS : MAX_OUT_COLS;
  localparam int CNT_W      = $clog2(MAX_DIM + 2) + 1;
  localparam int LINE_LEN   = MAX_OUT_COLS + 2;
  localparam int LINE_DEPTH = CHANNELS * LINE_LEN;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int PIX_W      = 16;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int SUM_W      = PROD_W + 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS = 2'd2;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHANNELS - 1);

  typedef struct packed {
    logic                    opcode;
    logic [5:0]              chan;
    logic [3:0]              tap;
    logic signed [PIX_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]              out_chan;
    logic [5:0]              out_row;
    logic [5:0]              out_col;
    logic signed [PIX_W-1:0] out_value;
    logic                    tile_last;
  } out_item_t;

  typedef struct packed {
    logic                    is_pix;
    logic [3:0]              tap;
    logic [CHAN_W-1:0]       chan;
    logic [LINE_AW-1:0]      laddr;
    logic                    emit;
    logic                    last;
    logic [5:0]              orow;
    logic [5:0]              ocol;
    logic signed [PIX_W-1:0] data;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/depthwise_conv3x3_stride.sv
// Top level of the depthwise 3x3 strided convolution block.
// Depends on dwc3_pkg, dwc3_front, dwc3_queue, dwc3_back.
//
// One item per cycle, weight or pixel. A pixel passes the queue, the read and
// multiply registers and the output register. The rate is set by the back end,
// which reads the line store, the column store and the nine weight stores once
// per item, so it stays at one item per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module depthwise_conv3x3_stride
  import dwc3_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire in_item_t             in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      out_item_t            out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);
  logic push, pop, q_full, q_empty;
  cmd_t cmd, head;

  dwc3_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  dwc3_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  dwc3_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef SYNTHESIS
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tile_last |-> out_data_o.out_chan == 6'(CHAN_LAST))
    else $error("tile end on wrong channel");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.out_col) < MAX_OUT_COLS)
    else $error("output column out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");
`endif
endmodule
`default_nettype wire

// File: hdl/dwc3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dwc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: hdl/dwc3_front.sv
// Front end: configuration registers, pixel position counters, item
// classification into commands. Depends on dwc3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dwc3_front
  import dwc3_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire in_item_t             in_data_i,
  output      logic                 in_stall_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 q_full_i,
  output      logic                 push_o,
  output      cmd_t                 cmd_o
);
  logic [2:0]        stride_q;
  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [CNT_W-1:0]  r_q, r_d, col_q, col_d;
  logic [CHAN_W-1:0] c_q, c_d;
  logic [1:0]        rph_q, rph_d, cph_q, cph_d;
  logic [5:0]        orow_q, orow_d, ocol_q, ocol_d;
  logic [2:0]        s_eff;
  logic [1:0]        s_m1;
  logic [CNT_W-1:0]  nr_eff, nc_eff;
  logic              accept, is_pix, w_ok, emit, last_row, last_col;
  logic              cfg_hit;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_pix     = (in_data_i.opcode == OP_PIXEL);
  assign w_ok       = (32'(in_data_i.chan) < CHANNELS) && (in_data_i.tap < 4'(TAPS));
  assign push_o     = accept && (is_pix || w_ok);

  always_comb begin
    if (stride_q == 3'd0) begin
      s_eff = 3'd1;
    end else if (stride_q > 3'd4) begin
      s_eff = 3'd4;
    end else begin
      s_eff = stride_q;
    end
    s_m1 = 2'(s_eff - 3'd1);
    if (rows_q == '0) begin
      nr_eff = CNT_W'(1);
    end else if (32'(rows_q) > MAX_OUT_ROWS) begin
      nr_eff = CNT_W'(MAX_OUT_ROWS);
    end else begin
      nr_eff = CNT_W'(rows_q);
    end
    if (cols_q == '0) begin
      nc_eff = CNT_W'(1);
    end else if (32'(cols_q) > MAX_OUT_COLS) begin
      nc_eff = CNT_W'(MAX_OUT_COLS);
    end else begin
      nc_eff = CNT_W'(cols_q);
    end
  end

  assign emit     = (r_q >= CNT_W'(2)) && (rph_q == 2'd0) &&
                    (col_q >= CNT_W'(2)) && (cph_q == 2'd0);
  assign last_row = ((CNT_W+1)'(r_q) + (CNT_W+1)'(s_eff)) >= ((CNT_W+1)'(nr_eff) + (CNT_W+1)'(2));
  assign last_col = ((CNT_W+1)'(col_q) + (CNT_W+1)'(s_eff)) >= ((CNT_W+1)'(nc_eff) + (CNT_W+1)'(2));

  always_comb begin
    cmd_o.is_pix = is_pix;
    cmd_o.tap    = in_data_i.tap;
    cmd_o.chan   = is_pix ? c_q : CHAN_W'(in_data_i.chan);
    cmd_o.laddr  = LINE_AW'(32'(c_q) * LINE_LEN + 32'(col_q));
    cmd_o.emit   = emit;
    cmd_o.last   = emit && last_row && last_col && (c_q == CHAN_LAST);
    cmd_o.orow   = orow_q;
    cmd_o.ocol   = ocol_q;
    cmd_o.data   = in_data_i.data_value;
  end

  // advance the raster position, channel fastest
  always_comb begin
    r_d = r_q;  col_d = col_q;  c_d = c_q;
    rph_d = rph_q;  cph_d = cph_q;  orow_d = orow_q;  ocol_d = ocol_q;
    if (c_q == CHAN_LAST) begin
      c_d = '0;
      if (col_q == nc_eff + CNT_W'(1)) begin
        col_d = '0;  cph_d = '0;  ocol_d = '0;
        if (r_q == nr_eff + CNT_W'(1)) begin
          r_d = '0;  rph_d = '0;  orow_d = '0;
        end else begin
          r_d = r_q + CNT_W'(1);
          if (r_q < CNT_W'(2)) begin
            rph_d = '0;  orow_d = '0;
          end else if (rph_q == s_m1) begin
            rph_d = '0;  orow_d = orow_q + 6'd1;
          end else begin
            rph_d = rph_q + 2'd1;
          end
        end
      end else begin
        col_d = col_q + CNT_W'(1);
        if (col_q < CNT_W'(2)) begin
          cph_d = '0;  ocol_d = '0;
        end else if (cph_q == s_m1) begin
          cph_d = '0;  ocol_d = ocol_q + 6'd1;
        end else begin
          cph_d = cph_q + 2'd1;
        end
      end
    end else begin
      c_d = c_q + CHAN_W'(1);
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == REG_STRIDE) || (cfg_idx_i == REG_OUT_ROWS) ||
                                (cfg_idx_i == REG_OUT_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= 3'd1;
      rows_q   <= CFG_W'(64);
      cols_q   <= CFG_W'(64);
      r_q <= '0;  col_q <= '0;  c_q <= '0;
      rph_q <= '0;  cph_q <= '0;  orow_q <= '0;  ocol_q <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_idx_i)
        REG_STRIDE:   stride_q <= cfg_data_i[2:0];
        REG_OUT_ROWS: rows_q   <= cfg_data_i;
        default:      cols_q   <= cfg_data_i;
      endcase
      r_q <= '0;  col_q <= '0;  c_q <= '0;
      rph_q <= '0;  cph_q <= '0;  orow_q <= '0;  ocol_q <= '0;
    end else if (accept && is_pix) begin
      r_q <= r_d;  col_q <= col_d;  c_q <= c_d;
      rph_q <= rph_d;  cph_q <= cph_d;  orow_q <= orow_d;  ocol_q <= ocol_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/dwc3_queue.sv
// Two-entry command queue between front and back end.
// Depends on dwc3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dwc3_queue
  import dwc3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output      logic full_o,
  output      logic empty_o,
  output      cmd_t head_o
);
  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;  rp_q <= 1'b0;  cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// File: hdl/dwc3_back.sv
// Back end: weight and line memories, window assembly, nine multiplies,
// sum, scale and saturate, output register. Depends on dwc3_pkg, dwc3_ram.
`timescale 1ns / 1ps
`default_nettype none
module dwc3_back
  import dwc3_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_empty_i,
  input  wire cmd_t      head_i,
  output      logic      pop_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_data_o
);
  logic                           en, a_wr;
  logic                           a_valid_q, b_valid_q, o_valid_q;
  cmd_t                           a_cmd_q, b_cmd_q;
  logic                           a_fl_q, a_fc_q;
  logic [2*PIX_W-1:0]             a_fl_data_q, line_rdata, line_rd, line_wdata;
  logic [6*PIX_W-1:0]             a_fc_data_q, col_rdata, col_rd, col_wdata;
  logic [3*PIX_W-1:0]             cur;
  logic [PIX_W-1:0]               w_rdata [TAPS];
  logic signed [PIX_W-1:0]        win [TAPS];
  logic signed [PROD_W-1:0]       prod_q [TAPS];
  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-9:0]        scaled;
  logic signed [PIX_W-1:0]        sat;
  out_item_t                      o_q;

  assign en    = !o_valid_q || !out_stall_i;
  assign pop_o = en && !q_empty_i;
  assign a_wr  = en && a_valid_q && a_cmd_q.is_pix;

  for (genvar k = 0; k < TAPS; k++) begin : g_w
    dwc3_ram #(.WIDTH(PIX_W), .DEPTH(CHANNELS)) u_wram (
      .clk_i   (clk_i),
      .we_i    (pop_o && !head_i.is_pix && (head_i.tap == 4'(k))),
      .waddr_i (head_i.chan),
      .wdata_i (head_i.data),
      .re_i    (pop_o),
      .raddr_i (head_i.chan),
      .rdata_o (w_rdata[k])
    );
  end

  dwc3_ram #(.WIDTH(2*PIX_W), .DEPTH(LINE_DEPTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (a_wr),
    .waddr_i (a_cmd_q.laddr),
    .wdata_i (line_wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.laddr),
    .rdata_o (line_rdata)
  );

  dwc3_ram #(.WIDTH(6*PIX_W), .DEPTH(CHANNELS)) u_cols (
    .clk_i   (clk_i),
    .we_i    (a_wr),
    .waddr_i (a_cmd_q.chan),
    .wdata_i (col_wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.chan),
    .rdata_o (col_rdata)
  );

  // line word: {row r-1, row r-2}; column word: {column c-1, column c-2}
  assign line_rd    = a_fl_q ? a_fl_data_q : line_rdata;
  assign col_rd     = a_fc_q ? a_fc_data_q : col_rdata;
  assign cur        = {a_cmd_q.data, line_rd};
  assign line_wdata = {a_cmd_q.data, line_rd[2*PIX_W-1:PIX_W]};
  assign col_wdata  = {cur, col_rd[6*PIX_W-1:3*PIX_W]};

  always_comb begin
    for (int m = 0; m < KSIZE; m++) begin
      win[m*KSIZE]     = col_rd[m*PIX_W +: PIX_W];
      win[m*KSIZE + 1] = col_rd[3*PIX_W + m*PIX_W +: PIX_W];
      win[m*KSIZE + 2] = cur[m*PIX_W +: PIX_W];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SUM_W'(prod_q[k]);
    end
    scaled = sum[SUM_W-1:8];
    if (scaled > (SUM_W-8)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (scaled < -(SUM_W-8)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = PIX_W'(scaled);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_cmd_q     <= head_i;
      a_fl_q      <= a_wr && (a_cmd_q.laddr == head_i.laddr);
      a_fl_data_q <= line_wdata;
      a_fc_q      <= a_wr && (a_cmd_q.chan == head_i.chan);
      a_fc_data_q <= col_wdata;
    end
    if (en) begin
      b_cmd_q <= a_cmd_q;
      for (int k = 0; k < TAPS; k++) begin
        prod_q[k] <= win[k] * $signed(w_rdata[k]);
      end
      o_q.out_chan  <= 6'(b_cmd_q.chan);
      o_q.out_row   <= b_cmd_q.orow;
      o_q.out_col   <= b_cmd_q.ocol;
      o_q.out_value <= sat;
      o_q.tile_last <= b_cmd_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;  b_valid_q <= 1'b0;  o_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= !q_empty_i;
      b_valid_q <= a_valid_q && a_cmd_q.is_pix && a_cmd_q.emit;
      o_valid_q <= b_valid_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;
endmodule
`default_nettype wire
